FILE: src/vsd_pkg.sv
// shared types, codes and mode geometry for the scan line and display start unit
package vsd_pkg;

  localparam int unsigned MAX_LINE_OFFSET   = 1023;
  localparam int unsigned OFF_W             = $clog2(MAX_LINE_OFFSET + 1);
  localparam int unsigned TEXT_WINDOW_BYTES = 32768;

  // serial arithmetic widths
  localparam int unsigned MUL_W   = 16;
  localparam int unsigned MUL_CW  = $clog2(MUL_W);
  localparam int unsigned DIV_DW  = 36;
  localparam int unsigned DIV_VW  = 16;
  localparam int unsigned DIV_CW  = $clog2(DIV_DW);

  // command codes
  localparam logic [2:0] ACT_SET_PIX   = 3'd0;
  localparam logic [2:0] ACT_GET       = 3'd1;
  localparam logic [2:0] ACT_SET_BYTES = 3'd2;
  localparam logic [2:0] ACT_GET_MAX   = 3'd3;
  localparam logic [2:0] ACT_SET_START = 3'd4;
  localparam logic [2:0] ACT_GET_START = 3'd5;
  localparam logic [2:0] ACT_RAW_START = 3'd6;
  localparam logic [2:0] ACT_UNKNOWN   = 3'd7;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_FAIL       = 3'd1;
  localparam logic [2:0] ST_HW_UNSUP   = 3'd2;
  localparam logic [2:0] ST_MODE_UNSUP = 3'd3;
  localparam logic [2:0] ST_UNIMPL     = 3'd4;

  // mode codes
  localparam logic [2:0] MODE_TEXT    = 3'd0;
  localparam logic [2:0] MODE_PLANAR4 = 3'd1;
  localparam logic [2:0] MODE_PACKED8 = 3'd2;
  localparam logic [2:0] MODE_RGB15   = 3'd3;
  localparam logic [2:0] MODE_RGB16   = 3'd4;
  localparam logic [2:0] MODE_RGB32   = 3'd6;

  // config register indexes
  localparam logic [2:0] CFG_MODE   = 3'd0;
  localparam logic [2:0] CFG_VMEM   = 3'd1;
  localparam logic [2:0] CFG_HEIGHT = 3'd2;
  localparam logic [2:0] CFG_ROWS   = 3'd3;
  localparam logic [2:0] CFG_CHAR_H = 3'd4;

  typedef struct packed {
    logic             ok;
    logic [2:0]       ppo_sh;  // log2 pixels per offset unit
    logic [1:0]       bpo_sh;  // log2 bytes per offset unit
    logic             pf2;     // panning factor of two
  } geom_t;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [2*MUL_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quot;
    logic [DIV_VW-1:0] rem;
  } div_rsp_t;

  function automatic geom_t mode_geom(logic [2:0] mode);
    geom_t g;
    g.ok     = 1'b1;
    g.ppo_sh = 3'd3;
    g.bpo_sh = 2'd3;
    g.pf2    = 1'b0;
    case (mode)
      MODE_TEXT: begin
        g.ppo_sh = 3'd4;
        g.bpo_sh = 2'd2;
      end
      MODE_PLANAR4: g.ppo_sh = 3'd4;
      MODE_PACKED8: begin
        g.ppo_sh = 3'd3;
        g.pf2    = 1'b1;
      end
      MODE_RGB15, MODE_RGB16: begin
        g.ppo_sh = 3'd2;
        g.pf2    = 1'b1;
      end
      MODE_RGB32: g.ppo_sh = 3'd1;
      default: g.ok = 1'b0;
    endcase
    return g;
  endfunction

endpackage

FILE: src/vsd_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
module vsd_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vsd_pkg::mul_req_t req_i,
  output vsd_pkg::mul_rsp_t rsp_o
);
  import vsd_pkg::*;

  logic                busy_q, done_q;
  logic [MUL_CW-1:0]   cnt_q;
  logic [2*MUL_W-1:0]  a_q, acc_q;
  logic [MUL_W-1:0]    b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= MUL_CW'(MUL_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= {{MUL_W{1'b0}}, req_i.a};
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      if (b_q[0]) acc_q <= acc_q + a_q;
      a_q <= {a_q[2*MUL_W-2:0], 1'b0};
      b_q <= {1'b0, b_q[MUL_W-1:1]};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;
endmodule

FILE: src/vsd_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module vsd_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vsd_pkg::div_req_t req_i,
  output vsd_pkg::div_rsp_t rsp_o
);
  import vsd_pkg::*;

  logic              busy_q, done_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [DIV_DW-1:0] quo_q;
  logic [DIV_VW-1:0] rem_q, dsr_q;
  logic [DIV_VW:0]   trial, diff;
  logic              ge;

  assign trial = {rem_q, quo_q[DIV_DW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = !diff[DIV_VW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CW'(DIV_DW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_VW-1:0] : trial[DIV_VW-1:0];
      quo_q <= {quo_q[DIV_DW-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;
endmodule

FILE: src/vbe_scanline_display_start_unit.sv
// top level: scan line length and display start command unit
//
// usage
// - command items enter on the in_valid_i / in_ready_o channel; each item
//   yields exactly one result item on out_valid_o / out_ready_i
// - config registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i
//   by the user only while the unit is idle; the unit does not enforce it;
//   unknown indexes are ignored
// - one item is worked at a time; in_ready_o is high while the sequencer
//   is idle, also while the previous result still waits in the output reg
// - serial units used, by command:
//     unknown, raw start, unsupported mode: none
//     get / set length: divider, plus multiplier in text mode
//     get max length: multiplier, divider if memory limits, then as above
//     set start: multiplier; get start: divider
// - the 36-bit restoring divider, one quotient bit per cycle, sets the pace
// - reset loads the register defaults (packed 8-bit mode, 2 MiB, 480 lines,
//   25 rows, 16-line cells) and clears offset, start and panning
// - a stalled receiver holds the result in the output reg; the next item
//   can be accepted and worked, but its result waits until the reg frees up
module vbe_scanline_display_start_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [26:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic [15:0] length_value_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [31:0] raw_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] bytes_per_line_o,
  output logic [15:0] pixels_per_line_o,
  output logic [15:0] max_lines_o,
  output logic [15:0] start_x_o,
  output logic [15:0] start_y_o
);
  import vsd_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CHK    = 9'b000000010,
    S_OFFDIV = 9'b000000100,
    S_BYTES  = 9'b000001000,
    S_LINES  = 9'b000010000,
    S_TEXT   = 9'b000100000,
    S_POSMUL = 9'b001000000,
    S_POSDIV = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [2:0]  mode_q;
  logic [26:0] vmem_q;
  logic [12:0] height_q;
  logic [7:0]  rows_q;
  logic [5:0]  chh_q;

  // architectural state
  logic [OFF_W-1:0] line_off_q, line_off_d;
  logic [31:0]      crtc_q, crtc_d;
  logic [7:0]       pan_q, pan_d;

  // working regs
  logic [OFF_W-1:0] off_q, off_d;
  logic [15:0]      px_q, px_d;
  logic [2:0]       res_st_q, res_st_d;
  logic [15:0]      res_bpl_q, res_bpl_d, res_ppl_q, res_ppl_d, res_lines_q, res_lines_d;
  logic [15:0]      res_sx_q, res_sx_d, res_sy_q, res_sy_d;

  // output reg
  logic out_valid_q, load_out;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  vsd_mul u_mul (.clk_i, .rst_ni, .req_i(mul_req), .rsp_o(mul_rsp));
  vsd_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  // mode dependent geometry
  geom_t       geom;
  logic        is_text;
  logic [26:0] vmem;
  logic [12:0] height;
  logic [15:0] width, bytes, pixels;
  logic [2:0]  half_sh, rem_mask;
  logic [1:0]  unit_sh_hi;
  logic [2:0]  unit_sh;
  logic [16:0] off_full;
  logic [32:0] pix;

  assign geom     = mode_geom(mode_q);
  assign is_text  = (mode_q == MODE_TEXT);
  assign vmem     = is_text ? 27'(TEXT_WINDOW_BYTES) : vmem_q;
  assign height   = is_text ? {5'b0, rows_q} : height_q;
  assign width    = 16'(line_off_q) << geom.ppo_sh;
  assign bytes    = 16'(off_q) << geom.bpo_sh;
  assign pixels   = 16'(off_q) << geom.ppo_sh;
  assign half_sh  = geom.ppo_sh - 3'd1;
  assign rem_mask = 3'((4'd1 << half_sh) - 4'd1);
  assign unit_sh_hi = geom.bpo_sh;
  assign unit_sh  = (action_i == ACT_SET_PIX) ? geom.ppo_sh : {1'b0, unit_sh_hi};
  // rounded-up offset in units
  assign off_full = ({1'b0, length_value_i} + ((17'd1 << unit_sh) - 17'd1)) >> unit_sh;
  assign pix      = 33'(mul_rsp.prod) + 33'(px_q);

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    line_off_d  = line_off_q;
    crtc_d      = crtc_q;
    pan_d       = pan_q;
    off_d       = off_q;
    px_d        = px_q;
    res_st_d    = res_st_q;
    res_bpl_d   = res_bpl_q;
    res_ppl_d   = res_ppl_q;
    res_lines_d = res_lines_q;
    res_sx_d    = res_sx_q;
    res_sy_d    = res_sy_q;
    mul_req     = '0;
    div_req     = '0;
    load_out    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_st_d    = ST_OK;
          res_bpl_d   = '0;
          res_ppl_d   = '0;
          res_lines_d = '0;
          res_sx_d    = '0;
          res_sy_d    = '0;
          state_d     = S_DONE;
          if (action_i == ACT_UNKNOWN) begin
            res_st_d = ST_UNIMPL;
          end else if (action_i == ACT_RAW_START) begin
            crtc_d = raw_start_i;
          end else if (!geom.ok) begin
            res_st_d = ST_MODE_UNSUP;
          end else begin
            case (action_i)
              ACT_SET_PIX, ACT_SET_BYTES: begin
                if (off_full > 17'(MAX_LINE_OFFSET)) begin
                  res_st_d = ST_HW_UNSUP;
                end else begin
                  line_off_d = off_full[OFF_W-1:0];
                  off_d      = off_full[OFF_W-1:0];
                  state_d    = S_BYTES;
                end
              end
              ACT_GET: begin
                off_d   = line_off_q;
                state_d = S_BYTES;
              end
              ACT_GET_MAX: begin
                if (height == '0) begin
                  off_d   = OFF_W'(MAX_LINE_OFFSET);
                  state_d = S_BYTES;
                end else begin
                  mul_req.start = 1'b1;
                  mul_req.a     = 16'(MAX_LINE_OFFSET);
                  mul_req.b     = 16'(height);
                  state_d       = S_CHK;
                end
              end
              ACT_SET_START: begin
                mul_req.start = 1'b1;
                mul_req.a     = width;
                mul_req.b     = pos_y_i;
                px_d          = pos_x_i;
                state_d       = S_POSMUL;
              end
              default: begin
                // get start
                if (width == '0) begin
                  res_st_d = ST_FAIL;
                end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = (DIV_DW'(crtc_q) << half_sh)
                                     + DIV_DW'(pan_q >> geom.pf2);
                  div_req.divisor  = width;
                  state_d          = S_POSDIV;
                end
              end
            endcase
          end
        end
      end
      S_CHK: begin
        if (mul_rsp.done) begin
          // does the full-length screen overflow memory
          if ((35'(mul_rsp.prod) << geom.bpo_sh) > 35'(vmem)) begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_DW'(vmem);
            div_req.divisor  = {3'b0, height} << geom.bpo_sh;
            state_d          = S_OFFDIV;
          end else begin
            off_d   = OFF_W'(MAX_LINE_OFFSET);
            state_d = S_BYTES;
          end
        end
      end
      S_OFFDIV: begin
        if (div_rsp.done) begin
          off_d   = div_rsp.quot[OFF_W-1:0];
          state_d = S_BYTES;
        end
      end
      S_BYTES: begin
        if (bytes == '0) begin
          res_st_d = ST_FAIL;
          state_d  = S_DONE;
        end else begin
          res_bpl_d        = bytes;
          res_ppl_d        = pixels;
          div_req.start    = 1'b1;
          div_req.dividend = DIV_DW'(vmem);
          div_req.divisor  = bytes;
          state_d          = S_LINES;
        end
      end
      S_LINES: begin
        if (div_rsp.done) begin
          if (is_text) begin
            mul_req.start = 1'b1;
            mul_req.a     = div_rsp.quot[15:0];
            mul_req.b     = 16'(chh_q);
            state_d       = S_TEXT;
          end else begin
            res_lines_d = div_rsp.quot[15:0];
            state_d     = S_DONE;
          end
        end
      end
      S_TEXT: begin
        if (mul_rsp.done) begin
          res_lines_d = mul_rsp.prod[15:0];
          state_d     = S_DONE;
        end
      end
      S_POSMUL: begin
        if (mul_rsp.done) begin
          crtc_d  = 32'(pix >> half_sh);
          pan_d   = 8'({5'b0, pix[2:0] & rem_mask} << geom.pf2);
          state_d = S_DONE;
        end
      end
      S_POSDIV: begin
        if (div_rsp.done) begin
          res_sx_d = div_rsp.rem[15:0];
          res_sy_d = div_rsp.quot[15:0];
          state_d  = S_DONE;
        end
      end
      S_DONE: begin
        // hand over once the output reg is free or being emptied
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_PACKED8;
      vmem_q      <= 27'd2097152;
      height_q    <= 13'd480;
      rows_q      <= 8'd25;
      chh_q       <= 6'd16;
      line_off_q  <= '0;
      crtc_q      <= '0;
      pan_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      line_off_q <= line_off_d;
      crtc_q     <= crtc_d;
      pan_q      <= pan_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MODE:   mode_q   <= cfg_wdata_i[2:0];
          CFG_VMEM:   vmem_q   <= cfg_wdata_i;
          CFG_HEIGHT: height_q <= cfg_wdata_i[12:0];
          CFG_ROWS:   rows_q   <= cfg_wdata_i[7:0];
          CFG_CHAR_H: chh_q    <= cfg_wdata_i[5:0];
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    off_q       <= off_d;
    px_q        <= px_d;
    res_st_q    <= res_st_d;
    res_bpl_q   <= res_bpl_d;
    res_ppl_q   <= res_ppl_d;
    res_lines_q <= res_lines_d;
    res_sx_q    <= res_sx_d;
    res_sy_q    <= res_sy_d;
    if (load_out) begin
      status_o          <= res_st_q;
      bytes_per_line_o  <= res_bpl_q;
      pixels_per_line_o <= res_ppl_q;
      max_lines_o       <= res_lines_q;
      start_x_o         <= res_sx_q;
      start_y_o         <= res_sy_q;
    end
  end

  assign out_valid_o = out_valid_q;
endmodule
